// ===== rtl/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
`timescale 1ns / 1ps

package ffha_pkg;

    // Default sizing of the block table and heap layout
    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int MIN_SPLIT_DEF    = 8;

    // Largest request that still rounds up without wrapping
    localparam logic [31:0] REQ_MAX = 32'hFFFF_FFF8;

    // Item operation codes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_HEAP_BASE = 1'b0;
    localparam logic CFG_HEAP_TOP  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_SIZE = 3'd1,
        ST_NO_SPACE = 3'd2,
        ST_NULL     = 3'd3,
        ST_UNKNOWN  = 3'd4,
        ST_DBL_FREE = 3'd5
    } t_status;

    // One entry of the block table
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic        free;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_SRCH_RD, S_SRCH_EV, S_NOTFOUND,
        S_INS_START, S_INS_CHK, S_INS_MV,
        S_MRG_RD, S_MRG_LD, S_MRG_CHK, S_MRG_EV,
        S_RM_CHK, S_RM_MV,
        S_ST_INIT, S_ST_RD, S_ST_ACC, S_FIN
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP, DP_LOAD, DP_NEXT, DP_GRANT, DP_GRANT_SPLIT, DP_DFREE,
        DP_MARK_FREE, DP_UNKNOWN, DP_NOSPACE, DP_GROW,
        DP_INS_START, DP_INS_MOVE, DP_INS_NEW,
        DP_LATCH_CUR, DP_MERGE, DP_ADVANCE, DP_RM_MOVE, DP_RM_DONE,
        DP_ST_START, DP_ST_ACC, DP_OUT
    } t_dp_op;

    typedef enum logic [1:0] {
        RD_IDX, RD_IDX_P1, RD_J_M1, RD_J_P1
    } t_rd_sel;

    typedef struct packed {
        t_dp_op  op;
        logic    rd_en;
        t_rd_sel rd_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic is_alloc;
        logic early;
        logic idx_end;
        logic hit;
        logic split_ok;
        logic rd_free;
        logic grow_ok;
        logic ins_at;
        logic mrg_end;
        logic can_merge;
        logic rm_end;
    } t_dp_stat;

endpackage

// ===== rtl/ffha_dp.sv =====
// Datapath: block table memory, heap registers, search and statistics arithmetic.
`timescale 1ns / 1ps

module ffha_dp #(
    parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int MIN_SPLIT    = ffha_pkg::MIN_SPLIT_DEF,
    localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_op,
    input  logic [31:0]        i_req_size,
    input  logic [31:0]        i_release_addr,
    input  ffha_pkg::t_dp_cmd  i_cmd,
    output ffha_pkg::t_dp_stat o_stat,
    output logic               o_valid,
    output logic [31:0]        o_payload_addr,
    output logic [2:0]         o_status,
    output logic [31:0]        o_alloc_bytes,
    output logic [31:0]        o_spare_bytes,
    output logic [CW-1:0]      o_count,
    output logic [CW-1:0]      o_nfree,
    output logic [31:0]        o_largest_free,
    output logic [31:0]        o_end_addr
);

    localparam int          AW          = $clog2(MAX_BLOCKS);
    localparam logic [31:0] HDR         = 32'(HEADER_BYTES);
    localparam logic [33:0] SPLIT_EXTRA = 34'(HEADER_BYTES) + 34'(MIN_SPLIT);
    localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_BLOCKS);

    // Block table
    ffha_pkg::t_entry mem [MAX_BLOCKS];

    logic [CW-1:0]     r_count, r_idx, r_j, r_pos;
    logic [31:0]       r_end, r_top, r_aligned, r_raddr, r_addr;
    logic              r_op, r_valid;
    ffha_pkg::t_status r_status;
    ffha_pkg::t_entry  r_new, r_cur, r_rd;
    logic [31:0]       r_used, r_freeb, r_largest;
    logic [CW-1:0]     r_nfree;

    logic [CW-1:0]     idx_p1, j_p1, j_m1;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic              wr_en;
    ffha_pkg::t_entry  wr_data;

    assign idx_p1 = r_idx + 1'b1;
    assign j_p1   = r_j + 1'b1;
    assign j_m1   = r_j - 1'b1;

    // Read address select
    always_comb begin
        unique case (i_cmd.rd_sel)
            ffha_pkg::RD_IDX:    rd_addr = r_idx[AW-1:0];
            ffha_pkg::RD_IDX_P1: rd_addr = idx_p1[AW-1:0];
            ffha_pkg::RD_J_M1:   rd_addr = j_m1[AW-1:0];
            ffha_pkg::RD_J_P1:   rd_addr = j_p1[AW-1:0];
            default:             rd_addr = r_idx[AW-1:0];
        endcase
    end

    // Write port
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_idx[AW-1:0];
        wr_data = r_rd;
        unique case (i_cmd.op)
            ffha_pkg::DP_GRANT:       wr_data.free = 1'b0;
            ffha_pkg::DP_GRANT_SPLIT: wr_data = '{start: r_rd.start, size: r_aligned, free: 1'b0};
            ffha_pkg::DP_MARK_FREE:   wr_data.free = 1'b1;
            ffha_pkg::DP_GROW: begin
                wr_addr = r_count[AW-1:0];
                wr_data = '{start: r_end, size: r_aligned, free: 1'b0};
            end
            ffha_pkg::DP_INS_MOVE, ffha_pkg::DP_RM_MOVE: wr_addr = r_j[AW-1:0];
            ffha_pkg::DP_INS_NEW: begin
                wr_addr = r_j[AW-1:0];
                wr_data = r_new;
            end
            ffha_pkg::DP_MERGE: wr_data = '{start: r_cur.start,
                                            size: r_cur.size + HDR + r_rd.size, free: 1'b1};
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Status towards the controller
    always_comb begin
        o_stat.is_alloc  = (r_op == ffha_pkg::OP_ALLOC);
        o_stat.early     = (r_status != ffha_pkg::ST_OK);
        o_stat.idx_end   = (r_idx == r_count);
        o_stat.hit       = o_stat.is_alloc ? (r_rd.free && (r_rd.size >= r_aligned))
                                           : ((r_rd.start + HDR) == r_raddr);
        o_stat.split_ok  = ({2'b00, r_rd.size} >= ({2'b00, r_aligned} + SPLIT_EXTRA))
                           && (r_count < CNT_MAX);
        o_stat.rd_free   = r_rd.free;
        o_stat.grow_ok   = (r_count < CNT_MAX) && (r_end <= r_top)
                           && ((33'(HDR) + 33'(r_aligned)) <= 33'(r_top - r_end));
        o_stat.ins_at    = (r_j == r_pos);
        o_stat.mrg_end   = (idx_p1 >= r_count);
        o_stat.can_merge = r_cur.free && r_rd.free
                           && ((r_cur.start + HDR + r_cur.size) == r_rd.start);
        o_stat.rm_end    = (j_p1 >= r_count);
    end

    // Heap state, configuration and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_end   <= '0;
            r_top   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == ffha_pkg::DP_OUT);
            if (i_cfg_we) begin
                if (i_cfg_idx == ffha_pkg::CFG_HEAP_BASE) begin
                    r_count <= '0;
                    r_end   <= i_cfg_wdata;
                end else begin
                    r_top <= i_cfg_wdata;
                end
            end
            unique case (i_cmd.op)
                ffha_pkg::DP_GROW: begin
                    r_count <= r_count + 1'b1;
                    r_end   <= r_end + HDR + r_aligned;
                end
                ffha_pkg::DP_INS_NEW: r_count <= r_count + 1'b1;
                ffha_pkg::DP_RM_DONE: r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    // Item registers, walk indexes and accumulators
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            ffha_pkg::DP_LOAD: begin
                r_op      <= i_op;
                r_aligned <= (i_req_size + 32'd7) & ~32'd7;
                r_raddr   <= i_release_addr;
                r_addr    <= '0;
                r_idx     <= '0;
                if (i_op == ffha_pkg::OP_ALLOC) begin
                    r_status <= ((i_req_size == '0) || (i_req_size > ffha_pkg::REQ_MAX))
                                ? ffha_pkg::ST_BAD_SIZE : ffha_pkg::ST_OK;
                end else begin
                    r_status <= (i_release_addr == '0) ? ffha_pkg::ST_NULL
                                                       : ffha_pkg::ST_OK;
                end
            end
            ffha_pkg::DP_NEXT:  r_idx <= idx_p1;
            ffha_pkg::DP_GRANT: r_addr <= r_rd.start + HDR;
            ffha_pkg::DP_GRANT_SPLIT: begin
                r_addr <= r_rd.start + HDR;
                r_pos  <= idx_p1;
                r_new  <= '{start: r_rd.start + HDR + r_aligned,
                            size: r_rd.size - r_aligned - HDR, free: 1'b1};
            end
            ffha_pkg::DP_DFREE:     r_status <= ffha_pkg::ST_DBL_FREE;
            ffha_pkg::DP_MARK_FREE: r_idx <= '0;
            ffha_pkg::DP_UNKNOWN:   r_status <= ffha_pkg::ST_UNKNOWN;
            ffha_pkg::DP_NOSPACE:   r_status <= ffha_pkg::ST_NO_SPACE;
            ffha_pkg::DP_GROW:      r_addr <= r_end + HDR;
            ffha_pkg::DP_INS_START: r_j <= r_count;
            ffha_pkg::DP_INS_MOVE:  r_j <= j_m1;
            ffha_pkg::DP_LATCH_CUR: r_cur <= r_rd;
            ffha_pkg::DP_MERGE: begin
                r_cur.size <= r_cur.size + HDR + r_rd.size;
                r_j        <= idx_p1;
            end
            ffha_pkg::DP_ADVANCE: begin
                r_cur <= r_rd;
                r_idx <= idx_p1;
            end
            ffha_pkg::DP_RM_MOVE: r_j <= j_p1;
            ffha_pkg::DP_ST_START: begin
                r_idx     <= '0;
                r_used    <= '0;
                r_freeb   <= '0;
                r_nfree   <= '0;
                r_largest <= '0;
            end
            ffha_pkg::DP_ST_ACC: begin
                r_idx <= idx_p1;
                if (r_rd.free) begin
                    r_freeb <= r_freeb + r_rd.size;
                    r_nfree <= r_nfree + 1'b1;
                    if (r_rd.size > r_largest) begin
                        r_largest <= r_rd.size;
                    end
                end else begin
                    r_used <= r_used + r_rd.size;
                end
            end
            default: ;
        endcase
    end

    assign o_valid        = r_valid;
    assign o_payload_addr = r_addr;
    assign o_status       = r_status;
    assign o_alloc_bytes  = r_used;
    assign o_spare_bytes  = r_freeb;
    assign o_count        = r_count;
    assign o_nfree        = r_nfree;
    assign o_largest_free = r_largest;
    assign o_end_addr     = r_end;

endmodule

// ===== rtl/ffha_ctrl.sv =====
// Controller: sequences search, insert, coalesce and statistics walks over the table.
`timescale 1ns / 1ps

module ffha_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ffha_pkg::t_dp_stat i_stat,
    output ffha_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);

    ffha_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffha_pkg::S_IDLE:    if (i_start) n_state = ffha_pkg::S_CHK;
            ffha_pkg::S_CHK:     n_state = i_stat.early ? ffha_pkg::S_ST_INIT
                                                        : ffha_pkg::S_SRCH_RD;
            ffha_pkg::S_SRCH_RD: n_state = i_stat.idx_end ? ffha_pkg::S_NOTFOUND
                                                          : ffha_pkg::S_SRCH_EV;
            ffha_pkg::S_SRCH_EV: begin
                if (!i_stat.hit) begin
                    n_state = ffha_pkg::S_SRCH_RD;
                end else if (i_stat.is_alloc) begin
                    n_state = i_stat.split_ok ? ffha_pkg::S_INS_START : ffha_pkg::S_ST_INIT;
                end else begin
                    n_state = i_stat.rd_free ? ffha_pkg::S_ST_INIT : ffha_pkg::S_MRG_RD;
                end
            end
            ffha_pkg::S_NOTFOUND:  n_state = ffha_pkg::S_ST_INIT;
            ffha_pkg::S_INS_START: n_state = ffha_pkg::S_INS_CHK;
            ffha_pkg::S_INS_CHK:   n_state = i_stat.ins_at ? ffha_pkg::S_ST_INIT
                                                           : ffha_pkg::S_INS_MV;
            ffha_pkg::S_INS_MV:    n_state = ffha_pkg::S_INS_CHK;
            ffha_pkg::S_MRG_RD:    n_state = ffha_pkg::S_MRG_LD;
            ffha_pkg::S_MRG_LD:    n_state = ffha_pkg::S_MRG_CHK;
            ffha_pkg::S_MRG_CHK:   n_state = i_stat.mrg_end ? ffha_pkg::S_ST_INIT
                                                            : ffha_pkg::S_MRG_EV;
            ffha_pkg::S_MRG_EV:    n_state = i_stat.can_merge ? ffha_pkg::S_RM_CHK
                                                              : ffha_pkg::S_MRG_CHK;
            ffha_pkg::S_RM_CHK:    n_state = i_stat.rm_end ? ffha_pkg::S_MRG_CHK
                                                           : ffha_pkg::S_RM_MV;
            ffha_pkg::S_RM_MV:     n_state = ffha_pkg::S_RM_CHK;
            ffha_pkg::S_ST_INIT:   n_state = ffha_pkg::S_ST_RD;
            ffha_pkg::S_ST_RD:     n_state = i_stat.idx_end ? ffha_pkg::S_FIN
                                                            : ffha_pkg::S_ST_ACC;
            ffha_pkg::S_ST_ACC:    n_state = ffha_pkg::S_ST_RD;
            ffha_pkg::S_FIN:       n_state = ffha_pkg::S_IDLE;
            default:               n_state = ffha_pkg::S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd.op     = ffha_pkg::DP_NOP;
        o_cmd.rd_en  = 1'b0;
        o_cmd.rd_sel = ffha_pkg::RD_IDX;
        unique case (r_state)
            ffha_pkg::S_IDLE: if (i_start) o_cmd.op = ffha_pkg::DP_LOAD;
            ffha_pkg::S_SRCH_RD: o_cmd.rd_en = !i_stat.idx_end;
            ffha_pkg::S_SRCH_EV: begin
                if (!i_stat.hit) begin
                    o_cmd.op = ffha_pkg::DP_NEXT;
                end else if (i_stat.is_alloc) begin
                    o_cmd.op = i_stat.split_ok ? ffha_pkg::DP_GRANT_SPLIT
                                               : ffha_pkg::DP_GRANT;
                end else begin
                    o_cmd.op = i_stat.rd_free ? ffha_pkg::DP_DFREE
                                              : ffha_pkg::DP_MARK_FREE;
                end
            end
            ffha_pkg::S_NOTFOUND: begin
                if (!i_stat.is_alloc) begin
                    o_cmd.op = ffha_pkg::DP_UNKNOWN;
                end else begin
                    o_cmd.op = i_stat.grow_ok ? ffha_pkg::DP_GROW : ffha_pkg::DP_NOSPACE;
                end
            end
            ffha_pkg::S_INS_START: o_cmd.op = ffha_pkg::DP_INS_START;
            ffha_pkg::S_INS_CHK: begin
                if (i_stat.ins_at) begin
                    o_cmd.op = ffha_pkg::DP_INS_NEW;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ffha_pkg::RD_J_M1;
                end
            end
            ffha_pkg::S_INS_MV: o_cmd.op = ffha_pkg::DP_INS_MOVE;
            ffha_pkg::S_MRG_RD: o_cmd.rd_en = 1'b1;
            ffha_pkg::S_MRG_LD: o_cmd.op = ffha_pkg::DP_LATCH_CUR;
            ffha_pkg::S_MRG_CHK: begin
                o_cmd.rd_en  = !i_stat.mrg_end;
                o_cmd.rd_sel = ffha_pkg::RD_IDX_P1;
            end
            ffha_pkg::S_MRG_EV: o_cmd.op = i_stat.can_merge ? ffha_pkg::DP_MERGE
                                                            : ffha_pkg::DP_ADVANCE;
            ffha_pkg::S_RM_CHK: begin
                if (i_stat.rm_end) begin
                    o_cmd.op = ffha_pkg::DP_RM_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ffha_pkg::RD_J_P1;
                end
            end
            ffha_pkg::S_RM_MV:   o_cmd.op = ffha_pkg::DP_RM_MOVE;
            ffha_pkg::S_ST_INIT: o_cmd.op = ffha_pkg::DP_ST_START;
            ffha_pkg::S_ST_RD:   o_cmd.rd_en = !i_stat.idx_end;
            ffha_pkg::S_ST_ACC:  o_cmd.op = ffha_pkg::DP_ST_ACC;
            ffha_pkg::S_FIN:     o_cmd.op = ffha_pkg::DP_OUT;
            default: ;
        endcase
    end

    assign o_busy = (r_state != ffha_pkg::S_IDLE);

endmodule

// ===== rtl/first_fit_heap_allocator_core.sv =====
// A rejected item goes from the check straight to the statistics walk over the table; any other
// item first searches the table, and a split or coalesce also shifts entries in it.
// Throughput: one item at a time; start is taken again the cycle o_valid pulses.
// Each result shows on the o_ ports for one cycle with o_valid; the receiver cannot stall.
// Reset (synchronous, active low) empties the table and clears heap base, top and end to 0.
`timescale 1ns / 1ps

module first_fit_heap_allocator_core #(
    parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
    parameter int MIN_SPLIT    = ffha_pkg::MIN_SPLIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_op,
    input  logic [31:0] i_req_size,
    input  logic [31:0] i_release_addr,
    output logic        o_valid,
    output logic [31:0] o_payload_addr,
    output logic [2:0]  o_status,
    output logic [31:0] o_alloc_bytes,
    output logic [31:0] o_spare_bytes,
    output logic [6:0]  o_block_total,
    output logic [6:0]  o_free_block_total,
    output logic [31:0] o_largest_free,
    output logic [31:0] o_end_addr
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);

    ffha_pkg::t_dp_cmd  cmd;
    ffha_pkg::t_dp_stat stat;
    logic [CW-1:0]      count, nfree;

    ffha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    ffha_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .MIN_SPLIT    (MIN_SPLIT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_op           (i_op),
        .i_req_size     (i_req_size),
        .i_release_addr (i_release_addr),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_payload_addr (o_payload_addr),
        .o_status       (o_status),
        .o_alloc_bytes  (o_alloc_bytes),
        .o_spare_bytes  (o_spare_bytes),
        .o_count        (count),
        .o_nfree        (nfree),
        .o_largest_free (o_largest_free),
        .o_end_addr     (o_end_addr)
    );

    // Counts reported at seven bits
    assign o_block_total      = 7'(count);
    assign o_free_block_total = 7'(nfree);

    // Result strobe lasts a single cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");

    // A result only closes a busy period
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy)) else $error("result without item");

    // An accepted item makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("item not taken");

    // Free blocks never outnumber all blocks
    a_free_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (nfree <= count)) else $error("free count exceeds table");

endmodule

// ===== tb/first_fit_heap_allocator_core_test.sv =====
// Self-checking testbench for the first-fit heap allocator core.
`timescale 1ns / 1ps

module first_fit_heap_allocator_core_test;

    localparam int          TABLE_DEPTH = ffha_pkg::MAX_BLOCKS_DEF;
    localparam logic [31:0] HDR         = 32'(ffha_pkg::HEADER_BYTES_DEF);
    localparam logic [33:0] SPLIT_MIN   = 34'(ffha_pkg::MIN_SPLIT_DEF);
    localparam int          IDLE_LIMIT  = 20000;
    localparam int          SETTLE      = 600;

    // One result item as seen on the output ports
    typedef struct packed {
        logic [31:0] payload_addr;
        logic [2:0]  status;
        logic [31:0] alloc_bytes;
        logic [31:0] spare_bytes;
        logic [6:0]  block_total;
        logic [6:0]  free_block_total;
        logic [31:0] largest_free;
        logic [31:0] end_addr;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_wdata;
    logic        i_start;
    logic        o_busy;
    logic        i_op;
    logic [31:0] i_req_size;
    logic [31:0] i_release_addr;
    logic        o_valid;
    logic [31:0] o_payload_addr;
    logic [2:0]  o_status;
    logic [31:0] o_alloc_bytes;
    logic [31:0] o_spare_bytes;
    logic [6:0]  o_block_total;
    logic [6:0]  o_free_block_total;
    logic [31:0] o_largest_free;
    logic [31:0] o_end_addr;

    first_fit_heap_allocator_core DUT (.*);

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Shadow of the allocator state
    logic [31:0] blk_start [TABLE_DEPTH];
    logic [31:0] blk_size  [TABLE_DEPTH];
    logic        blk_free  [TABLE_DEPTH];
    int          blk_count;
    logic [31:0] end_ptr;
    logic [31:0] cfg_top;

    t_outcome    pending_results[$];
    logic [31:0] live_addrs[$];
    int          mismatches;
    int          idle_cycles;

    function automatic void table_insert(int pos, logic [31:0] start, logic [31:0] size,
                                         logic fr);
        if (blk_count >= TABLE_DEPTH || pos > blk_count)
            return;
        for (int k = blk_count; k > pos; k--) begin
            blk_start[k] = blk_start[k-1];
            blk_size[k]  = blk_size[k-1];
            blk_free[k]  = blk_free[k-1];
        end
        blk_start[pos] = start;
        blk_size[pos]  = size;
        blk_free[pos]  = fr;
        blk_count++;
    endfunction

    // Merge contiguous free neighbours; block i is retested after each merge
    function automatic void coalesce();
        int i;
        i = 0;
        while (i + 1 < blk_count) begin
            if (blk_free[i] && blk_free[i+1] && blk_start[i] + HDR + blk_size[i] == blk_start[i+1])
            begin
                blk_size[i] = blk_size[i] + HDR + blk_size[i+1];
                for (int k = i + 1; k + 1 < blk_count; k++) begin
                    blk_start[k] = blk_start[k+1];
                    blk_size[k]  = blk_size[k+1];
                    blk_free[k]  = blk_free[k+1];
                end
                blk_count--;
            end else begin
                i++;
            end
        end
    endfunction

    // Apply one item to the shadow state and return the result it should give
    function automatic t_outcome predict_outcome(logic op, logic [31:0] size,
                                                 logic [31:0] addr);
        t_outcome    r;
        logic [31:0] aligned;
        bit          done;
        r = '0;
        r.status = ffha_pkg::ST_OK;
        if (op == ffha_pkg::OP_ALLOC) begin
            if (size == 0 || size > ffha_pkg::REQ_MAX) begin
                r.status = ffha_pkg::ST_BAD_SIZE;
            end else begin
                aligned = (size + 32'd7) & ~32'd7;
                done = 1'b0;
                for (int i = 0; i < blk_count && !done; i++) begin
                    if (blk_free[i] && blk_size[i] >= aligned) begin
                        if ({2'b0, blk_size[i]} >= {2'b0, aligned} + {2'b0, HDR} + SPLIT_MIN
                            && blk_count < TABLE_DEPTH) begin
                            table_insert(i + 1, blk_start[i] + HDR + aligned,
                                         blk_size[i] - aligned - HDR, 1'b1);
                            blk_size[i] = aligned;
                        end
                        blk_free[i]    = 1'b0;
                        r.payload_addr = blk_start[i] + HDR;
                        done = 1'b1;
                    end
                end
                // nothing fits: grow at the end pointer
                if (!done) begin
                    if (blk_count >= TABLE_DEPTH || end_ptr > cfg_top)
                        r.status = ffha_pkg::ST_NO_SPACE;
                    else if ({1'b0, aligned} + {1'b0, HDR} > {1'b0, cfg_top - end_ptr})
                        r.status = ffha_pkg::ST_NO_SPACE;
                    else begin
                        table_insert(blk_count, end_ptr, aligned, 1'b0);
                        r.payload_addr = end_ptr + HDR;
                        end_ptr = end_ptr + HDR + aligned;
                    end
                end
            end
        end else if (addr == 0) begin
            r.status = ffha_pkg::ST_NULL;
        end else begin
            r.status = ffha_pkg::ST_UNKNOWN;
            done = 1'b0;
            for (int i = 0; i < blk_count && !done; i++) begin
                if (blk_start[i] + HDR == addr) begin
                    done = 1'b1;
                    if (blk_free[i]) begin
                        r.status = ffha_pkg::ST_DBL_FREE;
                    end else begin
                        r.status = ffha_pkg::ST_OK;
                        blk_free[i] = 1'b1;
                        coalesce();
                    end
                end
            end
        end
        // usage statistics after the operation
        for (int i = 0; i < blk_count; i++) begin
            if (blk_free[i]) begin
                r.spare_bytes = r.spare_bytes + blk_size[i];
                r.free_block_total++;
                if (blk_size[i] > r.largest_free)
                    r.largest_free = blk_size[i];
            end else begin
                r.alloc_bytes = r.alloc_bytes + blk_size[i];
            end
        end
        r.block_total = 7'(blk_count);
        r.end_addr    = end_ptr;
        return r;
    endfunction

    // Send one item; start stays high so the next item can follow at once
    task automatic send_item(logic op, logic [31:0] size, logic [31:0] addr,
                             output logic [31:0] granted);
        t_outcome r;
        @(negedge i_clk);
        i_start        <= 1'b1;
        i_op           <= op;
        i_req_size     <= size;
        i_release_addr <= addr;
        do @(posedge i_clk); while (o_busy);
        r = predict_outcome(op, size, addr);
        pending_results.push_back(r);
        granted = r.payload_addr;
        if (op == ffha_pkg::OP_ALLOC && r.status == ffha_pkg::ST_OK)
            live_addrs.push_back(r.payload_addr);
    endtask

    task automatic alloc(logic [31:0] size);
        logic [31:0] g;
        send_item(ffha_pkg::OP_ALLOC, size, $urandom, g);
    endtask

    task automatic release_blk(logic [31:0] addr);
        logic [31:0] g;
        send_item(ffha_pkg::OP_RELEASE, $urandom, addr, g);
    endtask

    task automatic pause(int n);
        @(negedge i_clk);
        i_start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Stop sending and let every outstanding result come back
    task automatic drain();
        pause(0);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Register write once nothing is in flight; a base write empties the table
    task automatic write_reg(logic idx, logic [31:0] data);
        pause(0);
        while (o_busy || pending_results.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == ffha_pkg::CFG_HEAP_BASE) begin
            blk_count = 0;
            end_ptr   = data;
            live_addrs.delete();
        end else begin
            cfg_top = data;
        end
    endtask

    task automatic set_heap(logic [31:0] base, logic [31:0] top);
        write_reg(ffha_pkg::CFG_HEAP_BASE, base);
        write_reg(ffha_pkg::CFG_HEAP_TOP, top);
    endtask

    // Rejections, growth, split, double release and merging
    task automatic test_basic_ops();
        logic [31:0] a0, a1, a2, g;
        send_item(ffha_pkg::OP_ALLOC, 32'd8, 32'd0, g);   // reset heap has no room
        set_heap(32'h0000_1000, 32'h0000_1400);
        alloc(32'd0);
        alloc(32'hFFFF_FFF9);
        alloc(32'hFFFF_FFFF);
        alloc(ffha_pkg::REQ_MAX);
        release_blk(32'd0);
        release_blk(32'hFFFF_FFFF);
        release_blk(32'h0000_1234);
        send_item(ffha_pkg::OP_ALLOC, 32'd1, 32'd0, a0);
        send_item(ffha_pkg::OP_ALLOC, 32'd100, 32'd0, a1);
        send_item(ffha_pkg::OP_ALLOC, 32'd40, 32'd0, a2);
        release_blk(a0);
        release_blk(a0);
        release_blk(a1);                             // merges with the first block
        alloc(32'd8);                                // split of the merged block
        alloc(32'd24);
        alloc(32'd2000);
        release_blk(a2);
        drain();
    endtask

    // Growth near the top of the address space and a base above the top
    task automatic test_address_limits();
        set_heap(32'hFFFF_FF00, 32'hFFFF_FFFF);
        alloc(32'd200);
        alloc(32'd8);
        alloc(32'd40);
        release_blk(32'hFFFF_FF10);
        alloc(32'd16);
        drain();
        set_heap(32'h0000_0100, 32'h0000_0080);
        alloc(32'd8);
        drain();
    endtask

    // Full table: growth fails and a fitting free block is granted unsplit
    task automatic test_table_full();
        logic [31:0] big;
        set_heap(32'd0, 32'hFFFF_FFFF);
        send_item(ffha_pkg::OP_ALLOC, 32'd64, 32'd0, big);
        for (int i = 1; i < TABLE_DEPTH; i++)
            alloc(32'd8);
        alloc(32'd8);
        release_blk(big);
        alloc(32'd8);
        alloc(32'h7FFF_0000);
        drain();
    endtask

    // Random phases: mostly well-formed alloc/release traffic with noise
    task automatic test_random_traffic(int phases, int per_phase);
        logic [31:0] base, top, addr;
        int          burst, pick, idx;
        bit          gaps;
        for (int p = 0; p < phases; p++) begin
            base = $urandom;
            case ($urandom_range(0, 3))
                0: begin
                    base = 32'd0;
                    top  = 32'hFFFF_FFFF;
                end
                1:       top = base + $urandom_range(0, 400);
                default: top = base + $urandom_range(200, 3000);
            endcase
            if ($urandom_range(0, 9) == 0)
                top = $urandom;
            set_heap(base, top);
            gaps  = p % 3 != 0;
            burst = 0;
            for (int n = 0; n < per_phase; n++) begin
                if (gaps && burst == 0) begin
                    pause($urandom_range(1, 12));
                    burst = $urandom_range(1, 16);
                end
                burst--;
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    alloc($urandom_range(1, 160));
                else if (pick < 54)
                    alloc($urandom);
                else if (pick < 56)
                    alloc(32'd0);
                else if (pick < 90 && live_addrs.size() != 0) begin
                    idx  = $urandom_range(0, live_addrs.size() - 1);
                    addr = live_addrs[idx];
                    if ($urandom_range(0, 9) != 0)
                        live_addrs.delete(idx);
                    release_blk(addr);
                end else if (pick < 96)
                    release_blk($urandom);
                else
                    release_blk(32'd0);
            end
            drain();
        end
    endtask

    // Result checker and watchdog
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && ((i_start && !o_busy) || o_valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            got = '{o_payload_addr, o_status, o_alloc_bytes, o_spare_bytes, o_block_total,
                    o_free_block_total, o_largest_free, o_end_addr};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch at %0t", $realtime);
                        $display("  addr   exp %h got %h", want.payload_addr, got.payload_addr);
                        $display("  status exp %0d got %0d", want.status, got.status);
                        $display("  alloc  exp %h got %h", want.alloc_bytes, got.alloc_bytes);
                        $display("  spare  exp %h got %h", want.spare_bytes, got.spare_bytes);
                        $display("  blocks exp %0d got %0d", want.block_total, got.block_total);
                        $display("  fblk   exp %0d got %0d", want.free_block_total,
                                 got.free_block_total);
                        $display("  large  exp %h got %h", want.largest_free, got.largest_free);
                        $display("  end    exp %h got %h", want.end_addr, got.end_addr);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = ffha_pkg::CFG_HEAP_BASE;
        i_cfg_wdata    = '0;
        i_start        = 1'b0;
        i_op           = ffha_pkg::OP_ALLOC;
        i_req_size     = '0;
        i_release_addr = '0;
        mismatches     = 0;
        idle_cycles    = 0;
        blk_count      = 0;
        end_ptr        = '0;
        cfg_top        = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_ops();
        test_address_limits();
        test_table_full();
        test_random_traffic(17, 100);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ffha_pkg.sv
rtl/ffha_dp.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator_core.sv
tb/first_fit_heap_allocator_core_test.sv
